// File: design/rpfd_pkg.sv
// Package for the RTS pulse frame decoder.
// Holds the beat types, register and status codes and frame constants.
// Has no dependencies of its own.
package rpfd_pkg;

  localparam int FRAME_BYTES        = 7;
  localparam int FRAME_BITS         = FRAME_BYTES * 8;
  localparam int BIT_CNT_W          = $clog2(FRAME_BITS + 1);
  localparam int SYNC_CNT_W         = 4;
  localparam int SYNC_PULSES_NEEDED = 4;
  localparam int QUEUE_DEPTH_DEF    = 2;

  localparam logic [15:0] GLITCH_FLOOR_US = 16'd448;
  localparam logic [3:0]  NIBBLE_MASK     = 4'hF;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

  localparam logic [2:0] CFG_HW_SYNC_MIN = 3'd0;
  localparam logic [2:0] CFG_HW_SYNC_MAX = 3'd1;
  localparam logic [2:0] CFG_SW_SYNC_MIN = 3'd2;
  localparam logic [2:0] CFG_SW_SYNC_MAX = 3'd3;
  localparam logic [2:0] CFG_HALF_MIN    = 3'd4;
  localparam logic [2:0] CFG_HALF_MAX    = 3'd5;
  localparam logic [2:0] CFG_FULL_MIN    = 3'd6;
  localparam logic [2:0] CFG_FULL_MAX    = 3'd7;

  typedef struct packed {
    logic [15:0] pulse_us;
    logic        last_pulse;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] address;
    logic [15:0] rolling_code;
    logic [3:0]  command;
  } out_item_t;

  typedef struct packed {
    logic [15:0] hw_sync_min;
    logic [15:0] hw_sync_max;
    logic [15:0] sw_sync_min;
    logic [15:0] sw_sync_max;
    logic [15:0] half_min;
    logic [15:0] half_max;
    logic [15:0] full_min;
    logic [15:0] full_max;
  } cfg_t;

  typedef struct packed {
    logic                  no_frame;
    logic [FRAME_BITS-1:0] bits;
  } event_t;

endpackage

// File: design/rts_pulse_frame_decoder.sv
// Top level of the RTS pulse frame decoder.
// Instantiates rpfd_front, rpfd_queue and rpfd_back; depends on rpfd_pkg.
//
// Each input beat carries one pulse duration in microseconds and a flag for
// the last pulse of a capture. The front end takes one beat per cycle while
// the queue has room and updates sync counting and bit assembly in that
// same cycle. A completed frame, or a last pulse that ended a capture
// without one, becomes an event in a short queue. The back end decodes one
// event per cycle while the receiver is not stalling, into a registered
// result beat: status, address, rolling code and command. A result passes
// through the queue and then the output register. Sustained rate is one
// pulse per cycle while the queue has room, set by the front end update.
// While the receiver stalls, the output register holds its beat and the
// queue absorbs further events; in_ready drops only when the queue is full.
// The configuration port is always ready and writes one 16-bit window bound
// per beat. Reset restores the default windows and clears all decode state.
module rts_pulse_frame_decoder
  import rpfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t   cfg_r, cfg_nxt;
  logic   in_fire;
  logic   q_full, q_not_empty, q_pop, ev_push;
  event_t ev_data, q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HW_SYNC_MIN: cfg_nxt.hw_sync_min = cfg_data;
        CFG_HW_SYNC_MAX: cfg_nxt.hw_sync_max = cfg_data;
        CFG_SW_SYNC_MIN: cfg_nxt.sw_sync_min = cfg_data;
        CFG_SW_SYNC_MAX: cfg_nxt.sw_sync_max = cfg_data;
        CFG_HALF_MIN:    cfg_nxt.half_min    = cfg_data;
        CFG_HALF_MAX:    cfg_nxt.half_max    = cfg_data;
        CFG_FULL_MIN:    cfg_nxt.full_min    = cfg_data;
        CFG_FULL_MAX:    cfg_nxt.full_max    = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hw_sync_min <= 16'd1792;
      cfg_r.hw_sync_max <= 16'd3328;
      cfg_r.sw_sync_min <= 16'd3395;
      cfg_r.sw_sync_max <= 16'd6305;
      cfg_r.half_min    <= 16'd448;
      cfg_r.half_max    <= 16'd832;
      cfg_r.full_min    <= 16'd896;
      cfg_r.full_max    <= 16'd1664;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rpfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item_fire (in_fire),
    .item      (in_data),
    .ev_valid  (ev_push),
    .ev_data   (ev_data)
  );

  rpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rpfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (q_not_empty),
    .ev_data   (q_head),
    .ev_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_pulse |-> ev_push)
    else $error("Last pulse beat did not queue a result.");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push |-> !q_full || q_pop)
    else $error("Event pushed into a full queue.");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("Popped event did not reach the output register.");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STATUS_OK) |->
      (out_data.address == '0) && (out_data.rolling_code == '0) &&
      (out_data.command == '0) && (out_data.status != 2'd3))
    else $error("Result fields not zero for a failed frame.");

endmodule

// File: design/rpfd_front.sv
// Front end of the RTS pulse frame decoder: classifies pulses against the
// configured windows, tracks sync and bit assembly, and emits frame events.
// Depends on rpfd_pkg.
module rpfd_front
  import rpfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     item_fire,
  input  in_item_t item,
  output logic     ev_valid,
  output event_t   ev_data
);

  logic [SYNC_CNT_W-1:0] sync_cnt_r, sync_cnt_nxt;
  logic                  recv_r, recv_nxt;
  logic                  wait_half_r, wait_half_nxt;
  logic                  cur_bit_r, cur_bit_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [FRAME_BITS-1:0] bits_r, bits_nxt;

  logic glitch, hw_win, sw_win, half_win, full_win, frame_done;

  assign glitch   = item.pulse_us < GLITCH_FLOOR_US;
  assign hw_win   = (item.pulse_us > cfg.hw_sync_min) && (item.pulse_us < cfg.hw_sync_max);
  assign sw_win   = (item.pulse_us > cfg.sw_sync_min) && (item.pulse_us < cfg.sw_sync_max);
  assign half_win = (item.pulse_us > cfg.half_min) && (item.pulse_us < cfg.half_max);
  assign full_win = (item.pulse_us > cfg.full_min) && (item.pulse_us < cfg.full_max);

  always_comb begin
    sync_cnt_nxt  = sync_cnt_r;
    recv_nxt      = recv_r;
    wait_half_nxt = wait_half_r;
    cur_bit_nxt   = cur_bit_r;
    bit_cnt_nxt   = bit_cnt_r;
    bits_nxt      = bits_r;
    frame_done    = 1'b0;
    ev_valid      = 1'b0;
    ev_data       = '0;
    if (item_fire) begin
      if (!glitch) begin
        if (!recv_r) begin
          if (hw_win) begin
            if (sync_cnt_r != {SYNC_CNT_W{1'b1}}) begin
              sync_cnt_nxt = sync_cnt_r + 1'b1;
            end
          end else if (sw_win && (sync_cnt_r >= SYNC_CNT_W'(SYNC_PULSES_NEEDED))) begin
            recv_nxt      = 1'b1;
            wait_half_nxt = 1'b0;
            bit_cnt_nxt   = '0;
            cur_bit_nxt   = 1'b0;
            bits_nxt      = '0;
          end else begin
            sync_cnt_nxt = '0;
          end
        end else begin
          if (full_win && !wait_half_r) begin
            cur_bit_nxt = ~cur_bit_r;
            bits_nxt    = {bits_r[FRAME_BITS-2:0], ~cur_bit_r};
            bit_cnt_nxt = bit_cnt_r + 1'b1;
          end else if (half_win) begin
            if (wait_half_r) begin
              wait_half_nxt = 1'b0;
              bits_nxt      = {bits_r[FRAME_BITS-2:0], cur_bit_r};
              bit_cnt_nxt   = bit_cnt_r + 1'b1;
            end else begin
              wait_half_nxt = 1'b1;
            end
          end else begin
            recv_nxt     = 1'b0;
            sync_cnt_nxt = '0;
          end
          frame_done = recv_nxt && (bit_cnt_nxt == BIT_CNT_W'(FRAME_BITS));
        end
      end
      if (frame_done || item.last_pulse) begin
        ev_valid         = 1'b1;
        ev_data.no_frame = !frame_done;
        ev_data.bits     = frame_done ? bits_nxt : '0;
        sync_cnt_nxt     = '0;
        recv_nxt         = 1'b0;
        wait_half_nxt    = 1'b0;
        cur_bit_nxt      = 1'b0;
        bit_cnt_nxt      = '0;
        bits_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_cnt_r  <= '0;
      recv_r      <= 1'b0;
      wait_half_r <= 1'b0;
      cur_bit_r   <= 1'b0;
      bit_cnt_r   <= '0;
      bits_r      <= '0;
    end else begin
      sync_cnt_r  <= sync_cnt_nxt;
      recv_r      <= recv_nxt;
      wait_half_r <= wait_half_nxt;
      cur_bit_r   <= cur_bit_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      bits_r      <= bits_nxt;
    end
  end

endmodule

// File: design/rpfd_queue.sv
// Short event queue between the front end and the frame decoder.
// Stores event_t beats in a circular buffer; depends on rpfd_pkg.
module rpfd_queue
  import rpfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  event_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output event_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  event_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/rpfd_back.sv
// Back end of the RTS pulse frame decoder: de-obfuscates a frame, checks the
// nibble checksum and holds the result beat for the output channel.
// Depends on rpfd_pkg.
module rpfd_back
  import rpfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      ev_valid,
  input  event_t    ev_data,
  output logic      ev_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [7:0] raw [FRAME_BYTES];
  logic [7:0] dec [FRAME_BYTES];
  logic [3:0] csum;
  out_item_t  result;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;

  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      raw[i] = ev_data.bits[8 * (FRAME_BYTES - 1 - i) +: 8];
    end
    dec[0] = raw[0];
    for (int i = 1; i < FRAME_BYTES; i++) begin
      dec[i] = raw[i] ^ raw[i - 1];
    end
    csum = '0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      csum = csum ^ dec[i][7:4] ^ dec[i][3:0];
    end
    result = '0;
    if (ev_data.no_frame) begin
      result.status = STATUS_NO_FRAME;
    end else if ((csum & NIBBLE_MASK) != '0) begin
      result.status = STATUS_CHECKSUM;
    end else begin
      result.status       = STATUS_OK;
      result.address      = {dec[4], dec[5], dec[6]};
      result.rolling_code = {dec[2], dec[3]};
      result.command      = dec[1][7:4];
    end
  end

  assign ev_pop        = ev_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = ev_pop || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      out_data_r <= result;
    end
  end

endmodule
